[design/filled_circle_span_generator_core_macros.svh]
// assertion macros for the filled circle span generator
`ifndef FILLED_CIRCLE_SPAN_GENERATOR_CORE_MACROS_SVH
`define FILLED_CIRCLE_SPAN_GENERATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS

// consequent must hold in the same cycle as the antecedent
`define FCSG_CHECK_NOW(label, ck, rn, pre, post) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (pre) |-> (post)) \
        else $error("fcsg same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define FCSG_CHECK_NEXT(label, ck, rn, pre, post) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (pre) |=> (post)) \
        else $error("fcsg next-cycle check failed");

`else

`define FCSG_CHECK_NOW(label, ck, rn, pre, post)
`define FCSG_CHECK_NEXT(label, ck, rn, pre, post)

`endif

`endif

[design/fcsg_pkg.sv]
// shared constants, types and table function for the filled circle span generator
`default_nettype none

package fcsg_pkg;

    // defaults for the top level parameters
    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int MAX_RADIUS_DEF    = 32;
    localparam int COORD_BITS_DEF    = 12;

    // fixed field widths
    localparam int CLIP_BITS      = 11;
    localparam int RADIUS_IN_BITS = 6;
    localparam int COLOUR_BITS    = 8;
    localparam int CFG_INDEX_BITS = 2;
    localparam int FRAC_BITS      = 16;
    localparam int ROM_DATA_BITS  = 16;

    // clip window after reset
    localparam logic [CLIP_BITS-1:0] CLIP_X_MIN_RST = CLIP_BITS'(0);
    localparam logic [CLIP_BITS-1:0] CLIP_X_MAX_RST = CLIP_BITS'(639);
    localparam logic [CLIP_BITS-1:0] CLIP_Y_MIN_RST = CLIP_BITS'(0);
    localparam logic [CLIP_BITS-1:0] CLIP_Y_MAX_RST = CLIP_BITS'(479);

    // configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_CLIP_X_MIN = 2'd0,
        CFG_CLIP_X_MAX = 2'd1,
        CFG_CLIP_Y_MIN = 2'd2,
        CFG_CLIP_Y_MAX = 2'd3
    } cfg_index_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_ROWS,
        ST_DRAIN
    } fsm_state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic cmd_ready;
        logic div_start;
        logic step_load;
        logic row_issue;
    } ctrl_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic cmd_valid;
        logic empty_cmd;
        logic div_done;
        logic stall;
        logic row_past;
        logic row_final;
        logic pipe_busy;
    } dp_status_t;

    // width of row and column arithmetic, wide enough for coordinates and clip values
    function automatic int pos_bits(int coord_bits);
        if (coord_bits + 1 > CLIP_BITS + 1)
            return coord_bits + 1;
        return CLIP_BITS + 1;
    endfunction

    // quarter circle entry: sqrt(1-f^2) as Q0.16, rounded, saturated
    function automatic logic [ROM_DATA_BITS-1:0] hw_rom_entry(int e, int n);
        logic [63:0] d;
        logic [63:0] a;
        logic [63:0] num;
        logic [63:0] lim;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] t;
        longint      off;
        d   = 64'(n - 1);
        off = 2 * longint'(e) - longint'(n - 1);
        a   = (off < 0) ? 64'(-off) : 64'(off);
        num = d * d - a * a;
        lim = num << 34;
        lo  = 64'd0;
        hi  = 64'd65536;
        // binary search for the largest v with (2v-1)^2 d^2 <= 4 num 2^32
        for (int k = 0; k < 18; k++)
        begin
            if (lo < hi)
            begin
                mid = (lo + hi + 64'd1) >> 1;
                t   = 64'd2 * mid - 64'd1;
                if (t * t * d * d <= lim)
                    lo = mid;
                else
                    hi = mid - 64'd1;
            end
        end
        if (lo > 64'd65535)
            return 16'hFFFF;
        return lo[ROM_DATA_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

[design/fcsg_intf.sv]
// command, span and configuration channel interfaces
`default_nettype none

// circle command channel
interface fcsg_cmd_if #(parameter int COORD_BITS = fcsg_pkg::COORD_BITS_DEF);
    import fcsg_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [COORD_BITS-1:0]  centre_x;
    logic signed [COORD_BITS-1:0]  centre_y;
    logic [RADIUS_IN_BITS-1:0]     radius;
    logic [COLOUR_BITS-1:0]        pen_colour;
    logic                          see_through;

    modport source (output valid, centre_x, centre_y, radius, pen_colour, see_through,
                    input ready);
    modport sink   (input valid, centre_x, centre_y, radius, pen_colour, see_through,
                    output ready);
endinterface

// span result channel
interface fcsg_span_if #(parameter int COORD_BITS = fcsg_pkg::COORD_BITS_DEF);
    import fcsg_pkg::*;

    localparam int X_BITS = pos_bits(COORD_BITS);

    logic                      valid;
    logic                      ready;
    logic [CLIP_BITS-1:0]      span_row;
    logic signed [X_BITS-1:0]  span_start;
    logic signed [X_BITS-1:0]  span_end;
    logic                      span_drawn;
    logic [COLOUR_BITS-1:0]    span_colour;
    logic                      span_blend;
    logic                      last_span;

    modport source (output valid, span_row, span_start, span_end, span_drawn, span_colour,
                    span_blend, last_span, input ready);
    modport sink   (input valid, span_row, span_start, span_end, span_drawn, span_colour,
                    span_blend, last_span, output ready);
endinterface

// configuration write channel
interface fcsg_cfg_if;
    import fcsg_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CFG_INDEX_BITS-1:0]  index;
    logic [CLIP_BITS-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/fcsg_divider.sv]
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module fcsg_divider #(
    parameter int DVD_BITS = 27,
    parameter int DVS_BITS = 7
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [DVD_BITS-1:0] dividend,
    input  wire logic [DVS_BITS-1:0] divisor,
    output logic                     done,
    output logic [DVD_BITS-1:0]      quotient
);
    localparam int COUNT_BITS = (DVD_BITS > 1) ? $clog2(DVD_BITS) : 1;

    logic                  busy_reg;
    logic                  done_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [DVS_BITS-1:0]   rem_reg;
    logic [DVD_BITS-1:0]   quo_reg;
    logic [DVS_BITS-1:0]   dvs_reg;

    logic [DVS_BITS:0]     trial;
    logic                  fits;
    logic [DVS_BITS:0]     diff;
    logic [DVS_BITS-1:0]   rem_next;

    // shift in the next dividend bit and try the subtraction
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DVD_BITS-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = (trial >= {1'b0, dvs_reg});
        rem_next = fits ? diff[DVS_BITS-1:0] : trial[DVS_BITS-1:0];
    end

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + COUNT_BITS'(1);
                if (count_reg == COUNT_BITS'(DVD_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DVD_BITS-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[design/fcsg_datapath.sv]
// clip registers, row stepping, half-width table and span edge pipeline
`default_nettype none

module fcsg_datapath #(
    parameter int TABLE_ENTRIES = fcsg_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_RADIUS    = fcsg_pkg::MAX_RADIUS_DEF,
    parameter int COORD_BITS    = fcsg_pkg::COORD_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    fcsg_cmd_if.sink                 cmd,
    fcsg_span_if.source              span,
    fcsg_cfg_if.sink                 cfg,
    input  wire fcsg_pkg::ctrl_cmd_t ctl,
    output fcsg_pkg::dp_status_t     sts
);
    import fcsg_pkg::*;

    localparam int IDX_BITS  = $clog2(TABLE_ENTRIES);
    localparam int ACC_BITS  = IDX_BITS + FRAC_BITS;
    localparam int DVD_BITS  = ACC_BITS + 1;
    localparam int R_BITS    = $clog2(MAX_RADIUS + 1);
    localparam int DVS_BITS  = R_BITS + 1;
    localparam int POS_BITS  = pos_bits(COORD_BITS);
    localparam int PROD_BITS = ROM_DATA_BITS + R_BITS;

    localparam logic [DVD_BITS-1:0] DIVIDEND = DVD_BITS'(TABLE_ENTRIES) << FRAC_BITS;
    localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(TABLE_ENTRIES - 1);

    // clip window
    logic [CLIP_BITS-1:0] clip_x_min_reg;
    logic [CLIP_BITS-1:0] clip_x_max_reg;
    logic [CLIP_BITS-1:0] clip_y_min_reg;
    logic [CLIP_BITS-1:0] clip_y_max_reg;

    // command and row state
    logic signed [COORD_BITS-1:0] cx_reg;
    logic [R_BITS-1:0]            r_reg;
    logic [COLOUR_BITS-1:0]       colour_reg;
    logic                         blend_reg;
    logic signed [POS_BITS-1:0]   ybot_reg;
    logic signed [POS_BITS-1:0]   row_reg;
    logic [ACC_BITS-1:0]          acc_reg;
    logic [ACC_BITS-1:0]          step_reg;

    // pipeline stages
    logic                     s1_valid_reg;
    logic [ROM_DATA_BITS-1:0] rom_q_reg;
    logic [CLIP_BITS-1:0]     s1_row_reg;
    logic                     s1_last_reg;
    logic                     s2_valid_reg;
    logic [PROD_BITS-1:0]     w_reg;
    logic [CLIP_BITS-1:0]     s2_row_reg;
    logic                     s2_last_reg;
    logic                     out_valid_reg;
    logic [CLIP_BITS-1:0]     out_row_reg;
    logic signed [POS_BITS-1:0] out_start_reg;
    logic signed [POS_BITS-1:0] out_end_reg;
    logic                     out_drawn_reg;
    logic [COLOUR_BITS-1:0]   out_colour_reg;
    logic                     out_blend_reg;
    logic                     out_last_reg;

    // half-width table
    logic [ROM_DATA_BITS-1:0] rom_table [TABLE_ENTRIES];

    logic                       take;
    logic                       stall;
    logic [R_BITS-1:0]          r_in;
    logic signed [POS_BITS-1:0] cy_ext;
    logic signed [POS_BITS-1:0] r_in_ext;
    logic signed [POS_BITS-1:0] ytop_in;
    logic signed [POS_BITS-1:0] ybot_in;
    logic signed [POS_BITS-1:0] xmin_ext;
    logic signed [POS_BITS-1:0] xmax_ext;
    logic signed [POS_BITS-1:0] ymin_ext;
    logic signed [POS_BITS-1:0] ymax_ext;
    logic signed [POS_BITS-1:0] row_next;
    logic                       row_visible;
    logic                       row_last;
    logic [IDX_BITS-1:0]        idx_raw;
    logic [IDX_BITS-1:0]        idx;
    logic                       div_done;
    logic [DVD_BITS-1:0]        quotient;

    logic [R_BITS-1:0]          wh;
    logic                       wl_nz;
    logic signed [POS_BITS-1:0] cx_ext;
    logic signed [POS_BITS-1:0] wh_ext;
    logic signed [POS_BITS-1:0] d_left;
    logic signed [POS_BITS-1:0] d_right;
    logic signed [POS_BITS-1:0] xs_t;
    logic signed [POS_BITS-1:0] xe_t;
    logic signed [POS_BITS-1:0] xs_c;
    logic signed [POS_BITS-1:0] xe_c;
    logic                       drawn;

    // table contents fixed at elaboration
    for (genvar g = 0; g < TABLE_ENTRIES; g++)
    begin : g_rom
        assign rom_table[g] = hw_rom_entry(g, TABLE_ENTRIES);
    end

    // handshake and clip window widening
    always_comb
    begin
        take     = cmd.valid && ctl.cmd_ready;
        stall    = out_valid_reg && !span.ready;
        xmin_ext = POS_BITS'(clip_x_min_reg);
        xmax_ext = POS_BITS'(clip_x_max_reg);
        ymin_ext = POS_BITS'(clip_y_min_reg);
        ymax_ext = POS_BITS'(clip_y_max_reg);
    end

    // incoming command: radius saturation and vertical extent
    always_comb
    begin
        if (cmd.radius > RADIUS_IN_BITS'(MAX_RADIUS))
            r_in = R_BITS'(MAX_RADIUS);
        else
            r_in = cmd.radius[R_BITS-1:0];
        cy_ext   = POS_BITS'(cmd.centre_y);
        r_in_ext = POS_BITS'(r_in);
        ytop_in  = cy_ext - r_in_ext;
        ybot_in  = cy_ext + r_in_ext;
    end

    // current row tests and table index
    always_comb
    begin
        row_next    = row_reg + POS_BITS'(1);
        row_visible = (row_reg >= ymin_ext);
        row_last    = (row_next == ybot_reg) || (row_reg >= ymax_ext);
        idx_raw     = acc_reg[ACC_BITS-1:FRAC_BITS];
        idx         = (idx_raw > IDX_LAST) ? IDX_LAST : idx_raw;
    end

    // span ends: truncation toward zero worked on the integer and fraction parts
    always_comb
    begin
        wh      = w_reg[FRAC_BITS +: R_BITS];
        wl_nz   = |w_reg[FRAC_BITS-1:0];
        cx_ext  = POS_BITS'(cx_reg);
        wh_ext  = POS_BITS'(wh);
        d_left  = cx_ext - wh_ext;
        d_right = cx_ext + wh_ext;
        xs_t    = (wl_nz && (d_left > 0)) ? d_left - POS_BITS'(1) : d_left;
        xe_t    = (wl_nz && (d_right < 0)) ? d_right + POS_BITS'(1) : d_right;
        xs_c    = (xs_t < xmin_ext) ? xmin_ext : xs_t;
        xe_c    = (xe_t > xmax_ext) ? xmax_ext : xe_t;
        drawn   = (xs_c <= xmax_ext) && (xe_c >= xmin_ext);
    end

    // row step divider
    fcsg_divider #(
        .DVD_BITS (DVD_BITS),
        .DVS_BITS (DVS_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (DIVIDEND),
        .divisor  ({r_in, 1'b0}),
        .done     (div_done),
        .quotient (quotient)
    );

    // clip window registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_x_min_reg <= CLIP_X_MIN_RST;
            clip_x_max_reg <= CLIP_X_MAX_RST;
            clip_y_min_reg <= CLIP_Y_MIN_RST;
            clip_y_max_reg <= CLIP_Y_MAX_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                CFG_CLIP_X_MIN: clip_x_min_reg <= cfg.data;
                CFG_CLIP_X_MAX: clip_x_max_reg <= cfg.data;
                CFG_CLIP_Y_MIN: clip_y_min_reg <= cfg.data;
                CFG_CLIP_Y_MAX: clip_y_max_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            s1_valid_reg  <= ctl.row_issue && row_visible;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // command latch, row accumulator and step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            step_reg <= '0;
            row_reg  <= '0;
        end
        else
        begin
            if (take)
            begin
                acc_reg <= '0;
                row_reg <= ytop_in;
            end
            else if (ctl.row_issue)
            begin
                acc_reg <= acc_reg + step_reg;
                row_reg <= row_next;
            end
            if (ctl.step_load)
                step_reg <= quotient[ACC_BITS-1:0];
        end
    end

    // command payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cx_reg     <= cmd.centre_x;
            r_reg      <= r_in;
            colour_reg <= cmd.pen_colour;
            blend_reg  <= cmd.see_through;
            ybot_reg   <= ybot_in;
        end
    end

    // pipeline payload: table read, multiply, edges
    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            rom_q_reg      <= rom_table[idx];
            s1_row_reg     <= row_reg[CLIP_BITS-1:0];
            s1_last_reg    <= row_last;
            w_reg          <= rom_q_reg * r_reg;
            s2_row_reg     <= s1_row_reg;
            s2_last_reg    <= s1_last_reg;
            out_row_reg    <= s2_row_reg;
            out_start_reg  <= xs_c;
            out_end_reg    <= xe_c;
            out_drawn_reg  <= drawn;
            out_colour_reg <= colour_reg;
            out_blend_reg  <= blend_reg;
            out_last_reg   <= s2_last_reg;
        end
    end

    // channel outputs
    assign cmd.ready        = ctl.cmd_ready;
    assign cfg.ready        = 1'b1;
    assign span.valid       = out_valid_reg;
    assign span.span_row    = out_row_reg;
    assign span.span_start  = out_start_reg;
    assign span.span_end    = out_end_reg;
    assign span.span_drawn  = out_drawn_reg;
    assign span.span_colour = out_colour_reg;
    assign span.span_blend  = out_blend_reg;
    assign span.last_span   = out_last_reg;

    // status to the controller
    always_comb
    begin
        sts.cmd_valid = cmd.valid;
        sts.empty_cmd = (r_in == '0) || (ybot_in < ymin_ext);
        sts.div_done  = div_done;
        sts.stall     = stall;
        sts.row_past  = (row_reg > ymax_ext);
        sts.row_final = (row_next == ybot_reg);
        sts.pipe_busy = s1_valid_reg || s2_valid_reg;
    end

endmodule

`default_nettype wire

[design/fcsg_ctrl.sv]
// sequencer: command intake, division wait, row issue and drain
`default_nettype none

module fcsg_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire fcsg_pkg::dp_status_t sts,
    output fcsg_pkg::ctrl_cmd_t       ctl
);
    import fcsg_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                ctl.cmd_ready = 1'b1;
                if (sts.cmd_valid && !sts.empty_cmd)
                begin
                    ctl.div_start = 1'b1;
                    state_next    = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (sts.div_done)
                begin
                    ctl.step_load = 1'b1;
                    state_next    = ST_ROWS;
                end
            end
            ST_ROWS:
            begin
                if (!sts.stall)
                begin
                    if (sts.row_past)
                        state_next = ST_DRAIN;
                    else
                    begin
                        ctl.row_issue = 1'b1;
                        if (sts.row_final)
                            state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (!sts.pipe_busy)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/filled_circle_span_generator_core.sv]
// top level of the filled circle span generator
`default_nettype none

`include "filled_circle_span_generator_core_macros.svh"

// One circle command in, one span word out per visible row from centre_y-r to
// centre_y+r-1, clipped to the window set through the configuration channel.
// A command with zero radius, or one whose row centre_y+r lies above the window,
// is taken without a division and gives no spans. Otherwise the row step is found
// by a bit-serial divider, one quotient bit per cycle (log2(TABLE_ENTRIES)+17
// bits, 27 at the default table), and loaded; then one row is issued per cycle
// while the span channel does not stall, through a three-stage pipe of table
// read, half-width multiply and edge clamp; rows above the window are still
// issued but give no span. The next command is taken once the pipe ahead of the
// output register has emptied.
module filled_circle_span_generator_core #(
    parameter int TABLE_ENTRIES = fcsg_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_RADIUS    = fcsg_pkg::MAX_RADIUS_DEF,
    parameter int COORD_BITS    = fcsg_pkg::COORD_BITS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    fcsg_cmd_if.sink    cmd,
    fcsg_span_if.source span,
    fcsg_cfg_if.sink    cfg
);
    import fcsg_pkg::*;

    ctrl_cmd_t  ctl;
    dp_status_t sts;

    // sequencer
    fcsg_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .ctl   (ctl)
    );

    // datapath
    fcsg_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_RADIUS    (MAX_RADIUS),
        .COORD_BITS    (COORD_BITS)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .span  (span),
        .cfg   (cfg),
        .ctl   (ctl),
        .sts   (sts)
    );

    // a new command is only taken with no row in flight ahead of the output
    `FCSG_CHECK_NOW(a_ready_pipe_empty, clk, rst_n, cmd.ready, !sts.pipe_busy)

    // rows never advance while the output word is held
    `FCSG_CHECK_NOW(a_issue_no_stall, clk, rst_n, ctl.row_issue, !sts.stall)

    // a zero radius command leaves the block ready for the next one
    `FCSG_CHECK_NEXT(a_zero_radius_idle, clk, rst_n,
        cmd.valid && cmd.ready && (cmd.radius == '0), cmd.ready)

    // nothing follows the final span of a circle straight away
    `FCSG_CHECK_NEXT(a_last_then_gap, clk, rst_n,
        span.valid && span.ready && span.last_span, !span.valid)

endmodule

`default_nettype wire

[tb/fcsg_span_checker.sv]
// span checker: mirrors the clip window, predicts every span word and compares it
module fcsg_span_checker (
    input  logic clk,
    input  logic rst_n,
    fcsg_cmd_if  cmd,
    fcsg_span_if span,
    fcsg_cfg_if  cfg,
    output int   fail_count,
    output int   pending,
    output int   spans_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import fcsg_pkg::*;

    localparam int QUARTER_ENTRIES = 1024;
    localparam int RADIUS_LIMIT    = 32;
    localparam int XW              = COORD_BITS_DEF + 1;

    // one span word as it should leave the block
    typedef struct packed {
        logic [CLIP_BITS-1:0]   row;
        logic signed [XW-1:0]   x_left;
        logic signed [XW-1:0]   x_right;
        logic                   drawn;
        logic [COLOUR_BITS-1:0] colour;
        logic                   blend;
        logic                   tail;
    } span_word_t;

    logic [15:0]          quarter_table [QUARTER_ENTRIES];
    logic [CLIP_BITS-1:0] win_x_lo;
    logic [CLIP_BITS-1:0] win_x_hi;
    logic [CLIP_BITS-1:0] win_y_lo;
    logic [CLIP_BITS-1:0] win_y_hi;
    logic [25:0]          row_acc;
    logic [25:0]          row_inc;
    span_word_t           due_q [$];
    span_word_t           want;

    // half-width of the unit circle at table slot e, unsigned Q0.16, rounded
    function automatic logic [15:0] quarter_entry(int e);
        longint unsigned span_d;
        longint unsigned offs_mag;
        longint unsigned bound;
        longint unsigned cand;
        longint unsigned odd;
        longint unsigned best;
        longint          offs;
        span_d   = QUARTER_ENTRIES - 1;
        offs     = 2 * longint'(e) - longint'(QUARTER_ENTRIES - 1);
        offs_mag = (offs < 0) ? longint'(-offs) : offs;
        bound    = (span_d * span_d - offs_mag * offs_mag) << 34;
        best     = 0;
        // bitwise descent: largest v with (2v-1)^2 d^2 within the bound
        for (int b = 16; b >= 0; b--)
        begin
            cand = best | (64'd1 << b);
            odd  = 2 * cand - 1;
            if (cand <= 65536 && odd * odd * span_d * span_d <= bound)
                best = cand;
        end
        return (best > 65535) ? 16'hFFFF : best[15:0];
    endfunction

    // divide by 2^16, rounding toward zero
    function automatic longint trunc_frac(longint a);
        if (a >= 0)
            return a >>> 16;
        return -((-a) >>> 16);
    endfunction

    // queue the span words one circle gives under the current window
    function automatic void predict_circle(logic signed [COORD_BITS_DEF-1:0] cx_in,
                                           logic signed [COORD_BITS_DEF-1:0] cy_in,
                                           logic [RADIUS_IN_BITS-1:0] rad,
                                           logic [COLOUR_BITS-1:0] colour,
                                           logic blend);
        int         cx;
        int         cy;
        int         r;
        int         y;
        int         y_top;
        int         y_bot;
        int         produced;
        longint     half;
        longint     xs;
        longint     xe;
        span_word_t w;
        cx       = cx_in;
        cy       = cy_in;
        r        = (rad > RADIUS_LIMIT) ? RADIUS_LIMIT : int'(rad);
        produced = 0;
        if (r == 0)
            return;
        y_top = cy - r;
        y_bot = cy + r;
        if (y_bot < int'(win_y_lo))
            return;
        row_inc = 26'((longint'(QUARTER_ENTRIES) << 16) / (2 * r));
        row_acc = '0;
        for (y = y_top; y < y_bot; y++)
        begin
            if (y > int'(win_y_hi))
                break;
            if (y >= int'(win_y_lo))
            begin
                half = longint'(quarter_table[int'(row_acc[25:16])]) * r;
                xs   = trunc_frac(longint'(cx) * 65536 - half);
                xe   = trunc_frac(longint'(cx) * 65536 + half);
                if (xs < longint'(win_x_lo))
                    xs = longint'(win_x_lo);
                if (xe > longint'(win_x_hi))
                    xe = longint'(win_x_hi);
                w.row     = CLIP_BITS'(y);
                w.x_left  = XW'(xs);
                w.x_right = XW'(xe);
                w.drawn   = (xs <= longint'(win_x_hi)) && (xe >= longint'(win_x_lo));
                w.colour  = colour;
                w.blend   = blend;
                w.tail    = 1'b0;
                due_q.push_back(w);
                produced++;
            end
            row_acc = row_acc + row_inc;
        end
        if (produced > 0)
            due_q[due_q.size() - 1].tail = 1'b1;
    endfunction

    function automatic void check_field(string name, logic signed [63:0] want_v,
                                        logic signed [63:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want_v, got_v);
            fail_count++;
        end
    endfunction

    initial
    begin
        fail_count = 0;
        pending    = 0;
        spans_seen = 0;
        for (int e = 0; e < QUARTER_ENTRIES; e++)
            quarter_table[e] = quarter_entry(e);
    end

    // watch the three channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_x_lo = CLIP_X_MIN_RST;
            win_x_hi = CLIP_X_MAX_RST;
            win_y_lo = CLIP_Y_MIN_RST;
            win_y_hi = CLIP_Y_MAX_RST;
            row_acc  = '0;
            row_inc  = '0;
            due_q.delete();
        end
        else
        begin
            // span word against the oldest prediction
            if (span.valid === 1'b1 && span.ready === 1'b1)
            begin
                spans_seen++;
                if (due_q.size() == 0)
                begin
                    $display("%0t ns: span word with none expected, expected none, actual row %0d",
                             $time, span.span_row);
                    fail_count++;
                end
                else
                begin
                    want = due_q.pop_front();
                    check_field("span_row", want.row, span.span_row);
                    check_field("span_start", want.x_left, span.span_start);
                    check_field("span_end", want.x_right, span.span_end);
                    check_field("span_drawn", want.drawn, span.span_drawn);
                    check_field("span_colour", want.colour, span.span_colour);
                    check_field("span_blend", want.blend, span.span_blend);
                    check_field("last_span", want.tail, span.last_span);
                end
            end
            // clip register writes
            if (cfg.valid === 1'b1 && cfg.ready === 1'b1)
            begin
                case (cfg_index_t'(cfg.index))
                    CFG_CLIP_X_MIN: win_x_lo = cfg.data;
                    CFG_CLIP_X_MAX: win_x_hi = cfg.data;
                    CFG_CLIP_Y_MIN: win_y_lo = cfg.data;
                    CFG_CLIP_Y_MAX: win_y_hi = cfg.data;
                    default: ;
                endcase
            end
            // newly accepted circle
            if (cmd.valid === 1'b1 && cmd.ready === 1'b1)
                predict_circle(cmd.centre_x, cmd.centre_y, cmd.radius,
                               cmd.pen_colour, cmd.see_through);
        end
        pending = due_q.size();
    end

endmodule

[tb/filled_circle_span_generator_core_tb.sv]
// testbench top: clock, reset, circle and clip window stimulus, verdict
module filled_circle_span_generator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fcsg_pkg::*;

    localparam int CB            = COORD_BITS_DEF;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 200;
    localparam int CENTRE_MIN    = -2048;
    localparam int CENTRE_MAX    = 2047;

    logic clk;
    logic rst_n;
    int   idle_pct;
    int   stall_pct;
    bit   hold_request;
    int   circles_sent;
    int   windows_used;
    int   win_x_lo;
    int   win_x_hi;
    int   win_y_lo;
    int   win_y_hi;
    int   fail_count;
    int   pending_words;
    int   spans_seen;

    fcsg_cmd_if  cmd_ch ();
    fcsg_span_if span_ch ();
    fcsg_cfg_if  cfg_ch ();

    filled_circle_span_generator_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .span  (span_ch),
        .cfg   (cfg_ch)
    );

    fcsg_span_checker span_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .span       (span_ch),
        .cfg        (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending_words),
        .spans_seen (spans_seen)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // span receiver: random stalls, and a long hold-off on request
    initial
    begin
        int held;
        held          = 0;
        span_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && held < HOLD_CYCLES)
            begin
                span_ch.ready <= 1'b0;
                held++;
            end
            else
            begin
                if (hold_request)
                begin
                    hold_request = 1'b0;
                    held         = 0;
                end
                span_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // offer one circle word and wait for it to be taken
    task automatic send_circle(int cx, int cy, int r, int colour, bit thru);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.centre_x    <= CB'(cx);
        cmd_ch.centre_y    <= CB'(cy);
        cmd_ch.radius      <= RADIUS_IN_BITS'(r);
        cmd_ch.pen_colour  <= COLOUR_BITS'(colour);
        cmd_ch.see_through <= thru;
        @(posedge clk);
        while (cmd_ch.ready !== 1'b1)
            @(posedge clk);
        circles_sent++;
        @(negedge clk);
    endtask

    // coordinate around a window span, kept inside the field range
    function automatic int near_window(int a, int b);
        int lo;
        int hi;
        lo = ((a < b) ? a : b) - 40;
        hi = ((a < b) ? b : a) + 40;
        if (lo < CENTRE_MIN)
            lo = CENTRE_MIN;
        if (hi > CENTRE_MAX)
            hi = CENTRE_MAX;
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    task automatic random_circle(int force_r);
        int cx;
        int cy;
        int r;
        int pick;
        pick = $urandom_range(0, 9);
        if (force_r > 0)
            r = force_r;
        else if (pick == 0)
            r = 0;
        else if (pick == 1)
            r = $urandom_range(33, 63);
        else
            r = $urandom_range(1, 32);
        // mostly near the window, sometimes anywhere
        if ($urandom_range(0, 4) == 0)
        begin
            cx = int'($urandom_range(0, 4095)) - 2048;
            cy = int'($urandom_range(0, 4095)) - 2048;
        end
        else
        begin
            cx = near_window(win_x_lo, win_x_hi);
            cy = near_window(win_y_lo, win_y_hi);
        end
        send_circle(cx, cy, r, $urandom_range(0, 255), $urandom_range(0, 1));
    endtask

    // write all four clip registers
    task automatic set_window(int xl, int xh, int yl, int yh);
        int         vals [4];
        cfg_index_t regs [4];
        vals = '{xl, xh, yl, yh};
        regs = '{CFG_CLIP_X_MIN, CFG_CLIP_X_MAX, CFG_CLIP_Y_MIN, CFG_CLIP_Y_MAX};
        for (int k = 0; k < 4; k++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= regs[k];
            cfg_ch.data  <= CLIP_BITS'(vals[k]);
            @(posedge clk);
            while (cfg_ch.ready !== 1'b1)
                @(posedge clk);
            @(negedge clk);
        end
        cfg_ch.valid <= 1'b0;
        win_x_lo = xl;
        win_x_hi = xh;
        win_y_lo = yl;
        win_y_hi = yh;
        windows_used++;
    endtask

    // stop offering, wait for every predicted span, then let the block go idle
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        while (pending_words != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n              = 1'b0;
        idle_pct           = 0;
        stall_pct          = 0;
        hold_request       = 1'b0;
        circles_sent       = 0;
        windows_used       = 1;
        win_x_lo           = int'(CLIP_X_MIN_RST);
        win_x_hi           = int'(CLIP_X_MAX_RST);
        win_y_lo           = int'(CLIP_Y_MIN_RST);
        win_y_hi           = int'(CLIP_Y_MAX_RST);
        cmd_ch.valid       = 1'b0;
        cmd_ch.centre_x    = '0;
        cmd_ch.centre_y    = '0;
        cmd_ch.radius      = '0;
        cmd_ch.pen_colour  = '0;
        cmd_ch.see_through = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_CLIP_X_MIN;
        cfg_ch.data        = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed circles under the reset window
        send_circle(320, 240, 0, 8'h00, 1'b0);     // zero radius
        send_circle(320, 240, 1, 8'hFF, 1'b1);     // smallest circle
        send_circle(320, 240, 32, 8'h5A, 1'b0);    // largest radius
        send_circle(100, 100, 33, 8'hA5, 1'b1);    // radius saturates
        send_circle(100, 100, 63, 8'h01, 1'b0);    // radius field all ones
        send_circle(-2048, 200, 32, 8'h80, 1'b1);  // far left, nothing drawn
        send_circle(2047, 200, 20, 8'h7F, 0);      // far right, nothing drawn
        send_circle(300, -2048, 10, 8'h33, 1'b1);  // wholly above
        send_circle(300, -10, 10, 8'h44, 1'b0);    // bottom touches window top, all rows clipped
        send_circle(300, -11, 10, 8'h55, 1'b1);    // just above window
        send_circle(300, 2047, 32, 8'h66, 1'b0);   // wholly below
        send_circle(300, 5, 20, 8'h77, 1'b1);      // top rows clipped
        send_circle(300, 470, 20, 8'h88, 1'b0);    // stops below the window
        send_circle(3, 100, 10, 8'h99, 1'b1);      // straddles left edge
        send_circle(636, 100, 10, 8'hAA, 1'b0);    // straddles right edge
        send_circle(-5, 300, 4, 8'hBB, 1'b1);      // just left of window
        send_circle(645, 300, 5, 8'hCC, 1'b0);     // just right of window
        send_circle(0, 0, 1, 8'hDD, 1'b1);         // window corner
        send_circle(639, 479, 32, 8'hEE, 1'b0);    // opposite corner
        send_circle(-1, -1, 2, 8'h11, 1'b1);

        // random, no idling
        repeat (20) random_circle(0);
        settle();

        // small window, sender idle
        set_window(100, 300, 50, 200);
        idle_pct = 69;
        repeat (20) random_circle(0);
        settle();

        // widest window, receiver stalling
        set_window(0, 2047, 0, 2047);
        idle_pct  = 0;
        stall_pct = 69;
        repeat (20) random_circle(0);
        settle();

        // inverted window, both sides idling
        set_window(500, 100, 300, 20);
        idle_pct  = 17;
        stall_pct = 17;
        repeat (15) random_circle(0);
        settle();

        // single pixel windows at both extremes
        set_window(0, 0, 0, 0);
        repeat (10) random_circle(0);
        settle();
        set_window(2047, 2047, 2047, 2047);
        repeat (10) random_circle(0);
        settle();

        // long span hold-off while large circles keep coming
        set_window(0, 639, 0, 479);
        idle_pct  = 0;
        stall_pct = 0;
        @(posedge clk) hold_request = 1'b1;
        @(negedge clk);
        repeat (10) random_circle(32);
        settle();

        // sender pauses until each circle has fully drained
        stall_pct = 17;
        repeat (6)
        begin
            random_circle(0);
            settle();
        end

        $display("run covered %0d circle words and %0d span words over %0d clip windows,",
                 circles_sent, spans_seen, windows_used);
        $display("with idle and stall phases, a %0d-cycle span hold-off and drained pauses",
                 HOLD_CYCLES);
        if (fail_count == 0 && pending_words == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
